// ===== rtl/sha_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 byte hasher.
// Used by the hash memory, round core and top module under rtl; depends on nothing else.
package sha_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_HLOAD,
    S_ROUND,
    S_HSTORE,
    S_ORD,
    S_OLD
  } state_t;

  // Hash word memory access of the current cycle.
  typedef struct packed {
    logic [2:0]  rd_addr;
    logic        wr_en;
    logic [2:0]  wr_addr;
    logic [31:0] wr_data;
    logic        clear;
  } hash_ctl_t;

  // Round datapath operation of the current cycle.
  typedef struct packed {
    logic       load_h;
    logic       rotate;
    logic       round;
    logic       wt_load;
    logic       wt_from_mem;
    logic [5:0] rnd;
  } core_ctl_t;

  localparam logic [7:0] PAD_MARK       = 8'h80;
  localparam logic [5:0] LEN_START      = 6'd56;
  localparam logic [5:0] FILL_LAST      = 6'd63;
  localparam logic [5:0] ROUND_LAST     = 6'd63;
  localparam logic [5:0] HPASS_LAST     = 6'd8;
  localparam logic [5:0] HLOAD_BUF_RD   = 6'd7;
  localparam logic [5:0] SCHED_MEM_LAST = 6'd14;
  localparam logic [2:0] WORD_LAST      = 3'd7;

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned s);
    rotr = (x >> s) | (x << (32 - s));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== rtl/sha_buf_mem.sv =====
// Block buffer: 16 x 32-bit words, written one byte at a time, read a word.
// Big-endian lanes; depends on nothing but the clock.
module sha_buf_mem (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [5:0]  wr_addr,
  input  logic [7:0]  wr_byte,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rd_data
);

  logic [31:0] mem [16];

  // byte 0 of a word lands in the top lane
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/sha_hash_mem.sv =====
// Hash word memory: 8 x 32 bits, one read and one write port, registered read.
// Entries without a valid bit read as the initial hash values of sha_pkg.
module sha_hash_mem
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  hash_ctl_t   ctl,
  output logic [31:0] rd_data
);

  logic [31:0] mem [8];
  logic [7:0]  vld;
  logic [31:0] mem_q;
  logic [2:0]  rd_addr_q;
  logic        rd_vld_q;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    mem_q     <= mem[ctl.rd_addr];
    rd_addr_q <= ctl.rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld[ctl.rd_addr];
      if (ctl.clear) begin
        vld <= '0;
      end else if (ctl.wr_en) begin
        vld[ctl.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_q ? mem_q : HASH_IV[rd_addr_q];

endmodule

// ===== rtl/sha_round_core.sv =====
// Working variables, 16-word message schedule window and one round per cycle.
// Driven by core_ctl_t from sha_pkg; word data comes from the two memories.
module sha_round_core
  import sha_pkg::*;
(
  input  logic        clk,
  input  core_ctl_t   ctl,
  input  logic [31:0] hash_rdata,
  input  logic [31:0] buf_rdata,
  output logic [31:0] word_a
);

  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [31:0] wt_q;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] sched;

  assign ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1    = v[7] + big_sig1(v[4]) + ch + ROUND_K[ctl.rnd] + wt_q;
  assign t2    = big_sig0(v[0]) + maj;
  // next schedule word, loaded into wt_q ahead of the round that uses it
  assign sched = w[1] + small_sig0(w[2]) + w[10] + small_sig1(w[15]);

  always_ff @(posedge clk) begin
    if (ctl.load_h) begin
      v[0] <= hash_rdata;
      for (int i = 1; i < 8; i++) begin
        v[i] <= v[i-1];
      end
    end else if (ctl.rotate) begin
      for (int i = 0; i < 7; i++) begin
        v[i] <= v[i+1];
      end
      v[7] <= v[0];
    end else if (ctl.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end

    if (ctl.round) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= wt_q;
    end

    if (ctl.wt_load) begin
      wt_q <= ctl.wt_from_mem ? buf_rdata : sched;
    end
  end

  assign word_a = v[0];

endmodule

// ===== rtl/sha256_byte_stream_hasher.sv =====
// SHA-256 hasher over a byte stream, one byte per input transfer.
// Bytes are taken while idle; each full 64-byte block then holds input off while the
// hash memory is loaded, the rounds run and the hash words are read, added and stored.
// End of message: pad bytes are written, each padding block is compressed, then 8 digest
// words go out via hash memory read and output register. Synchronous rst restores the
// initial hash values, zero fill and zero length; the block buffer is not cleared.
module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  state_t      state;
  state_t      state_next;
  logic [5:0]  cnt;
  logic [5:0]  fill;
  logic [60:0] byte_cnt;
  logic [2:0]  oidx;
  logic        pend_end;
  logic        padding;
  logic        first_pad;
  logic        long_pad;
  logic        second_blk;

  logic        in_xfer;
  logic [63:0] bit_len;
  logic [5:0]  start_pos;
  logic [7:0]  pad_byte;
  logic        buf_wr_en;
  logic [7:0]  buf_wr_byte;
  logic [3:0]  buf_rd_addr;
  logic [31:0] buf_rdata;
  logic [31:0] hash_rdata;
  logic [31:0] word_a;
  hash_ctl_t   hctl;
  core_ctl_t   cctl;

  assign in_xfer  = in_valid && in_ready;
  assign bit_len  = {byte_cnt, 3'b000};
  // where the 0x80 mark goes: just past the byte of this transfer, if any
  assign start_pos = (state == S_IDLE && byte_present) ? fill + 6'd1 : fill;

  // Pad byte: mark first, length in the last eight bytes of the final block, else zero.
  always_comb begin
    if (first_pad) begin
      pad_byte = PAD_MARK;
    end else if ((!long_pad || second_blk) && fill >= LEN_START) begin
      pad_byte = bit_len[{~fill[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign buf_wr_en   = (in_xfer && byte_present) || state == S_PAD;
  assign buf_wr_byte = (state == S_PAD) ? pad_byte : data_byte;

  sha_buf_mem u_buf (
    .clk     (clk),
    .wr_en   (buf_wr_en),
    .wr_addr (fill),
    .wr_byte (buf_wr_byte),
    .rd_addr (buf_rd_addr),
    .rd_data (buf_rdata)
  );

  sha_hash_mem u_hash (
    .clk     (clk),
    .rst     (rst),
    .ctl     (hctl),
    .rd_data (hash_rdata)
  );

  sha_round_core u_core (
    .clk        (clk),
    .ctl        (cctl),
    .hash_rdata (hash_rdata),
    .buf_rdata  (buf_rdata),
    .word_a     (word_a)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (byte_present && fill == FILL_LAST) begin
            state_next = S_HLOAD;
          end else if (end_of_message) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (fill == FILL_LAST) state_next = S_HLOAD;
      end
      S_HLOAD: begin
        if (cnt == HPASS_LAST) state_next = S_ROUND;
      end
      S_ROUND: begin
        if (cnt == ROUND_LAST) state_next = S_HSTORE;
      end
      S_HSTORE: begin
        if (cnt == HPASS_LAST) begin
          if (pend_end || (padding && long_pad && !second_blk)) begin
            state_next = S_PAD;
          end else if (padding) begin
            state_next = S_ORD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_ORD: begin
        // read only once the output register is free by the next edge
        if (!out_valid || out_ready) state_next = S_OLD;
      end
      S_OLD: begin
        state_next = (oidx == WORD_LAST) ? S_IDLE : S_ORD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory and datapath control
  always_comb begin
    in_ready         = (state == S_IDLE);
    hctl             = '0;
    cctl             = '0;
    cctl.rnd         = cnt;
    buf_rd_addr      = cnt[3:0] + 4'd2;
    hctl.wr_addr     = cnt[2:0] - 3'd1;
    hctl.wr_data     = hash_rdata + word_a;
    unique case (state)
      S_HLOAD: begin
        // fetch hash words last-first so they shift into place, then prime the schedule
        hctl.rd_addr     = ~cnt[2:0];
        buf_rd_addr      = cnt[3:0] - HLOAD_BUF_RD[3:0];
        cctl.load_h      = (cnt != 6'd0);
        cctl.wt_load     = (cnt == HPASS_LAST);
        cctl.wt_from_mem = 1'b1;
      end
      S_ROUND: begin
        cctl.round       = 1'b1;
        cctl.wt_load     = 1'b1;
        cctl.wt_from_mem = (cnt <= SCHED_MEM_LAST);
      end
      S_HSTORE: begin
        // read word i, add the working variable and write the sum back in the next cycle
        hctl.rd_addr = cnt[2:0];
        hctl.wr_en   = (cnt != 6'd0);
        cctl.rotate  = (cnt != 6'd0);
      end
      S_ORD: begin
        hctl.rd_addr = oidx;
      end
      S_OLD: begin
        hctl.clear = (oidx == WORD_LAST);
      end
      S_IDLE, S_PAD: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      fill       <= '0;
      byte_cnt   <= '0;
      oidx       <= '0;
      pend_end   <= 1'b0;
      padding    <= 1'b0;
      first_pad  <= 1'b0;
      long_pad   <= 1'b0;
      second_blk <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? 6'd0 : cnt + 6'd1;

      // advance the byte pointer on every buffer write; it wraps at the block end
      if (buf_wr_en) fill <= fill + 6'd1;

      if (in_xfer && byte_present) byte_cnt <= byte_cnt + 61'd1;

      if (in_xfer) begin
        pend_end <= end_of_message && byte_present && fill == FILL_LAST;
      end else if (state == S_HSTORE && state_next == S_PAD) begin
        pend_end <= 1'b0;
      end

      if (state == S_PAD) first_pad <= 1'b0;

      if ((state == S_IDLE && state_next == S_PAD) ||
          (state == S_HSTORE && state_next == S_PAD && pend_end)) begin
        padding    <= 1'b1;
        first_pad  <= 1'b1;
        long_pad   <= (start_pos >= LEN_START);
        second_blk <= 1'b0;
      end else if (state == S_HSTORE && state_next == S_PAD) begin
        second_blk <= 1'b1;
      end

      if (state == S_OLD) begin
        oidx <= oidx + 3'd1;
        if (oidx == WORD_LAST) begin
          // drop the message state; hash memory clears its valid bits alongside
          byte_cnt   <= '0;
          padding    <= 1'b0;
          long_pad   <= 1'b0;
          second_blk <= 1'b0;
        end
      end
    end
  end

  // Output register: hold a digest word until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OLD) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OLD) begin
      digest_word <= hash_rdata;
      word_index  <= oidx;
      last_word   <= (oidx == WORD_LAST);
    end
  end

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    state == S_OLD |-> !out_valid)
    else $error("digest word loaded over a pending word");

  a_hash_rw_apart: assert property (@(posedge clk) disable iff (rst)
    hctl.wr_en |-> hctl.wr_addr != hctl.rd_addr)
    else $error("hash memory read and write hit the same entry");

  a_rounds_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && cnt == ROUND_LAST) |=> state == S_HSTORE)
    else $error("round sequence did not end in the hash update");

  a_last_then_gap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_word) |=> !out_valid)
    else $error("digest word follows the final word at once");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !padding && !pend_end)
    else $error("input taken while padding is pending");

endmodule

// ===== test/sha256_digest_checker.sv =====
`timescale 1ns / 1ps
// Digest scoreboard for sha256_byte_stream_hasher: runs SHA-256 over accepted bytes.
// Compares each digest word with the oldest expected one. Needs only the block's port widths.
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last_word,
  output int          mismatch_count,
  output int          words_pending,
  output int          words_checked
);

  typedef struct packed {
    logic [31:0] digest;
    logic [2:0]  position;
    logic        is_last;
  } digest_entry_t;

  localparam logic [7:0] PAD_BYTE      = 8'h80;
  localparam int         LENGTH_OFFSET = 56;
  localparam int         REPORT_LIMIT  = 10;

  localparam logic [31:0] CHAIN_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0]   chain [8];
  logic [7:0]    block_bytes [64];
  logic [5:0]    fill;
  logic [63:0]   bit_count;
  digest_entry_t expected_words [$];

  function automatic logic [31:0] ror32(input logic [31:0] x, input int s);
    return (x >> s) | (x << (32 - s));
  endfunction

  task automatic restart_message();
    for (int i = 0; i < 8; i++) chain[i] = CHAIN_INIT[i];
    for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    fill = 6'd0;
    bit_count = 64'd0;
  endtask

  task automatic compress_block_bytes();
    logic [31:0] sched [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++)
      sched[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
    for (int t = 16; t < 64; t++)
      sched[t] = sched[t-16]
               + (ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3))
               + sched[t-7]
               + (ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10));
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + SHA_K[t] + sched[t];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endtask

  task automatic absorb_byte(input logic [7:0] value);
    block_bytes[fill] = value;
    fill = fill + 6'd1;
    bit_count = bit_count + 64'd8;
    if (fill == 6'd0) compress_block_bytes();
  endtask

  // Pad, append the bit length, queue the eight words and start over.
  task automatic close_message();
    int start_pos;
    start_pos = fill;
    block_bytes[start_pos] = PAD_BYTE;
    for (int i = start_pos + 1; i < 64; i++) block_bytes[i] = 8'h00;
    if (start_pos >= LENGTH_OFFSET) begin
      compress_block_bytes();
      for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) block_bytes[63 - i] = bit_count[8*i +: 8];
    compress_block_bytes();
    for (int i = 0; i < 8; i++)
      expected_words.push_back('{digest: chain[i], position: 3'(i), is_last: (i == 7)});
    restart_message();
  endtask

  always @(posedge clk) begin : watch
    digest_entry_t want;
    if (rst) begin
      restart_message();
      expected_words.delete();
      mismatch_count = 0;
      words_checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("[%0t] unexpected digest word %h index %0d last %0b",
                     $realtime, digest_word, word_index, last_word);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          if (digest_word !== want.digest || word_index !== want.position ||
              last_word !== want.is_last) begin
            if (mismatch_count < REPORT_LIMIT)
              $display("[%0t] digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                       $realtime, want.digest, want.position, want.is_last,
                       digest_word, word_index, last_word);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (byte_present) absorb_byte(data_byte);
        if (end_of_message) close_message();
      end
    end
    words_pending = expected_words.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the SHA-256 byte stream hasher test: clock, reset, byte stream and output backpressure.
// Instantiates sha256_byte_stream_hasher and sha256_digest_checker, which predicts the digests.
module testbench;

  localparam int ITEM_TARGET  = 350;
  localparam int HOLD_CYCLES  = 800;   // long receiver hold-off, forces an input stall
  localparam int DRAIN_CYCLES = 300;   // idle run-out after the last digest has come back

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_present = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  int mismatch_count;
  int words_pending;
  int words_checked;

  // Bookkeeping of the stimulus; noise transfers do not count as items.
  int items_sent    = 0;
  int messages_sent = 0;
  int bytes_sent    = 0;
  int burst_left    = 0;
  int hold_requests = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sha256_byte_stream_hasher uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_word      (last_word)
  );

  sha256_digest_checker digest_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_word      (last_word),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending),
    .words_checked  (words_checked)
  );

  // Offer one item from a falling edge and hold it until the transfer.
  // Return at the following falling edge with valid still high, so that a
  // back-to-back item simply replaces the payload.
  task automatic send_item(input logic [7:0] value, input logic present, input logic ends);
    in_valid = 1'b1;
    data_byte = value;
    byte_present = present;
    end_of_message = ends;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (present || ends) items_sent++;
    if (present) bytes_sent++;
    if (ends) messages_sent++;
  endtask

  // Burst pacing: at the end of a burst drop valid for a random gap (often none).
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // Send one well-formed message of random bytes, sprinkled with empty items.
  // The end mark rides either on the last byte or on an empty end item.
  task automatic send_message(input int len);
    logic end_on_byte;
    end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      pace();
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte) begin
      pace();
      send_item(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  // Drop valid and hold until every predicted digest word has come back.
  task automatic wait_for_digests();
    in_valid = 1'b0;
    while (words_pending != 0) @(negedge clk);
  endtask

  initial begin
    int len;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed: empty message, ignored empty items, "abc", both ways of
    // ending a message, and the byte values 0x00 and 0xff.
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h80, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    wait_for_digests();

    // Ask the receiver for its long hold-off, then keep offering: the short
    // message's digest blocks the output and the next message backs up.
    hold_requests++;
    send_message(5);

    // Messages right at the padding boundaries: pad fits, pad spills into a
    // second block, and an exactly full block.
    send_message(55);
    send_message(56);
    send_message(64);
    wait_for_digests();

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(0, 3);
        1, 2:    len = $urandom_range(52, 66);
        3:       len = $urandom_range(116, 130);
        default: len = $urandom_range(1, 30);
      endcase
      send_message(len);
    end

    wait_for_digests();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Hashed %0d messages (%0d bytes, %0d items); %0d digest words checked.",
             messages_sent, bytes_sent, items_sent, words_checked);
    $display("Covered empty messages, empty items, pad boundaries and output stalls.");
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Receiver: cycle through segments of always-ready, coin-flip, sparse and
  // three-of-four patterns; honor a hold-off request as soon as it appears.
  initial begin
    int holds_done;
    int mode;
    int seg;
    int cyc;
    holds_done = 0;
    cyc = 0;
    while (rst) @(negedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      seg = $urandom_range(16, 160);
      while (seg > 0 && hold_requests == holds_done) begin
        case (mode)
          0:       out_ready = 1'b1;
          1:       out_ready = 1'($urandom_range(0, 1));
          2:       out_ready = ($urandom_range(0, 3) == 0);
          default: out_ready = (cyc % 4 != 3);
        endcase
        cyc++;
        seg--;
        @(negedge clk);
      end
      if (hold_requests != holds_done) begin
        holds_done++;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("Timeout: %0d digest words still outstanding.", words_pending);
    $display("FAIL");
    $finish;
  end

endmodule
